// ===== rtl/core/ltwcr_pkg.sv =====
// ----------------------------------------------------------------------------
// ltwcr_pkg
// types, constants and control store shared by the worker count regulator
// ----------------------------------------------------------------------------
package ltwcr_pkg;

    localparam int LOAD_W  = 18;
    localparam int CNT_W   = 8;
    localparam int PRE_O_W = 19;
    localparam int PROD_W  = 38;
    localparam int ACC_W   = 40;
    localparam int KC_W    = 20;

    // 1/(1-e) and e/(1-e) in q16, e = exp(-5/60)
    localparam logic [KC_W-1:0] K_Q16   = 20'd819655;
    localparam logic [KC_W-1:0] KM1_Q16 = 20'd754119;
    // ceil(2^19/3), exact floor(x/3) for x < 2^19
    localparam logic [KC_W-1:0] RECIP3  = 20'd174763;
    localparam int RECIP3_SH = 19;

    // configuration register indexes
    localparam logic [1:0] CFG_LOAD_TARGET = 2'd0;
    localparam logic [1:0] CFG_WORKER_MAX  = 2'd1;
    localparam logic [1:0] CFG_WORKER_MIN  = 2'd2;

    typedef logic [2:0] t_step;

    localparam t_step STEP_DISPATCH = 3'd0;
    localparam t_step STEP_CROSS    = 3'd1;
    localparam t_step STEP_DIFF     = 3'd2;
    localparam t_step STEP_STATS    = 3'd3;
    localparam t_step STEP_REG      = 3'd4;
    localparam t_step STEP_PRIME    = 3'd5;
    localparam t_step STEP_BYPASS   = 3'd6;

    typedef enum logic [1:0] {MA_SAMPLE, MA_PREV, MA_DEF} t_mul_a;
    typedef enum logic [1:0] {MK_K, MK_KM1, MK_RECIP} t_mul_k;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_SUB} t_acc_op;
    typedef enum logic [1:0] {EM_NONE, EM_REG, EM_PRIME, EM_BYPASS} t_emit;
    typedef enum logic {JC_NEXT, JC_DISPATCH} t_jump;

    typedef struct packed {
        logic    mul_en;
        t_mul_a  mul_a;
        t_mul_k  mul_k;
        t_acc_op acc_op;
        logic    ld_def;
        logic    ld_stats;
        t_emit   emit;
        t_jump   jc;
    } t_uword;

    typedef struct packed {
        logic   accept;
        logic   exec;
        t_uword u;
    } t_ctrl;

    typedef struct packed {
        logic is_prime;
        logic bypass;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic [LOAD_W-1:0] load_target;
        logic [CNT_W-1:0]  worker_max;
        logic [CNT_W-1:0]  worker_min;
    } t_cfg;

    // control store
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        w.mul_en   = 1'b0;
        w.mul_a    = MA_SAMPLE;
        w.mul_k    = MK_K;
        w.acc_op   = ACC_HOLD;
        w.ld_def   = 1'b0;
        w.ld_stats = 1'b0;
        w.emit     = EM_NONE;
        w.jc       = JC_NEXT;
        unique case (step)
            STEP_DISPATCH: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_SAMPLE;
                w.mul_k  = MK_K;
                w.ld_def = 1'b1;
                w.jc     = JC_DISPATCH;
            end
            STEP_CROSS: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_PREV;
                w.mul_k  = MK_KM1;
                w.acc_op = ACC_LOAD;
            end
            STEP_DIFF: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_DEF;
                w.mul_k  = MK_RECIP;
                w.acc_op = ACC_SUB;
            end
            STEP_STATS:  w.ld_stats = 1'b1;
            STEP_REG:    w.emit = EM_REG;
            STEP_PRIME:  w.emit = EM_PRIME;
            STEP_BYPASS: w.emit = EM_BYPASS;
            default:     w.emit = EM_BYPASS;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/ltwcr_if.sv =====
// ----------------------------------------------------------------------------
// ltwcr interfaces
// tick input, result output and configuration write channels
// ----------------------------------------------------------------------------
interface ltwcr_in_if;
    import ltwcr_pkg::*;
    logic              valid;
    logic              ready;
    logic [LOAD_W-1:0] load_sample;
    logic              prime;
    modport source (output valid, output load_sample, output prime, input ready);
    modport sink   (input valid, input load_sample, input prime, output ready);
endinterface

interface ltwcr_out_if;
    import ltwcr_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CNT_W-1:0]          worker_count;
    logic [LOAD_W-1:0]         recent_load;
    logic signed [PRE_O_W-1:0] target_before_clamp;
    logic [LOAD_W-1:0]         load_echo;
    logic                      stats_valid;
    modport source (output valid, output worker_count, output recent_load,
                    output target_before_clamp, output load_echo, output stats_valid,
                    input ready);
    modport sink   (input valid, input worker_count, input recent_load,
                    input target_before_clamp, input load_echo, input stats_valid,
                    output ready);
endinterface

interface ltwcr_cfg_if;
    import ltwcr_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        index;
    logic [LOAD_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/load_target_worker_count_regulator.sv =====
// ----------------------------------------------------------------------------
// load_target_worker_count_regulator
// turns periodic load average ticks into a worker count via a fractional target
// ----------------------------------------------------------------------------
//  channel   dir  transaction
//  i_in      in   one tick: load_sample (q10.8), prime
//  o_out     out  one result per tick: worker_count, recent_load,
//                 target_before_clamp, load_echo, stats_valid
//  i_cfg     in   register write: index (0 load_target, 1 worker_max,
//                 2 worker_min), data
//
//  a regulating tick runs five microcode steps after its accept cycle; prime
//  and bypass ticks run dispatch, then their emitting step; no new tick is
//  taken until the current one emits; the single shared 18x20 multiplier forms
//  the two inverse-average products and the divide-by-three reciprocal in turn
//  synchronous active-low reset: target 255.0 workers, previous load zero,
//  load_target 0, worker_max 8, worker_min 0
//  a tick is taken while the previous result waits; the emitting step holds
//  until the result register is free
//  config writes are always ready
// ----------------------------------------------------------------------------
module load_target_worker_count_regulator #(
    parameter int MAX_WORKERS    = 255,
    parameter int LOAD_FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ltwcr_in_if.sink    i_in,
    ltwcr_out_if.source o_out,
    ltwcr_cfg_if.sink   i_cfg
);
    import ltwcr_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.load_target <= '0;
            r_cfg.worker_max  <= 8'd8;
            r_cfg.worker_min  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LOAD_TARGET: r_cfg.load_target <= i_cfg.data;
                CFG_WORKER_MAX:  r_cfg.worker_max  <= i_cfg.data[CNT_W-1:0];
                CFG_WORKER_MIN:  r_cfg.worker_min  <= i_cfg.data[CNT_W-1:0];
                default:         r_cfg <= r_cfg; // unused index, write dropped
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // sequencer and datapath
    t_ctrl    w_ctrl;
    t_dp_stat w_stat;
    logic     w_busy;

    ltwcr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (i_in.ready),
        .o_busy     (w_busy),
        .o_ctrl     (w_ctrl)
    );

    ltwcr_dp #(
        .MAX_WORKERS    (MAX_WORKERS),
        .LOAD_FRAC_BITS (LOAD_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_cfg         (r_cfg),
        .i_load_sample (i_in.load_sample),
        .i_prime       (i_in.prime),
        .o_stat        (w_stat),
        .o_out         (o_out)
    );

    // an accepted tick keeps the sequencer running
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> w_busy)
        else $error("sequencer idle after tick accept");

    // regulated results never fall below the configured minimum
    a_min_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stats_valid) |-> (o_out.worker_count >= r_cfg.worker_min))
        else $error("worker count below minimum");

    // results without statistics carry zeroed statistics
    a_stats_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.stats_valid) |->
        (o_out.recent_load == '0 && o_out.target_before_clamp == '0))
        else $error("statistics set on unregulated result");

endmodule

// ===== rtl/core/ltwcr_seq.sv =====
// ----------------------------------------------------------------------------
// ltwcr_seq
// step counter, control store fetch and dispatch jumps
// ----------------------------------------------------------------------------
module ltwcr_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ltwcr_pkg::t_dp_stat i_stat,
    output logic                o_in_ready,
    output logic                o_busy,
    output ltwcr_pkg::t_ctrl    o_ctrl
);
    import ltwcr_pkg::*;

    logic   r_busy, n_busy;
    t_step  r_step, n_step;
    t_uword w_u;
    logic   w_accept, w_exec;

    assign w_u      = ucode_rom(r_step);
    assign w_accept = i_in_valid && !r_busy;
    // an emitting step waits for room in the result register
    assign w_exec   = r_busy && ((w_u.emit == EM_NONE) || i_stat.out_free);

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (w_accept) begin
            n_busy = 1'b1;
            n_step = STEP_DISPATCH;
        end else if (w_exec) begin
            if (w_u.emit != EM_NONE) begin
                n_busy = 1'b0;
                n_step = STEP_DISPATCH;
            end else if (w_u.jc == JC_DISPATCH && i_stat.is_prime) begin
                n_step = STEP_PRIME;
            end else if (w_u.jc == JC_DISPATCH && i_stat.bypass) begin
                n_step = STEP_BYPASS;
            end else begin
                n_step = r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_DISPATCH;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_in_ready    = !r_busy;
    assign o_busy        = r_busy;
    assign o_ctrl.accept = w_accept;
    assign o_ctrl.exec   = w_exec;
    assign o_ctrl.u      = w_u;

endmodule

// ===== rtl/core/ltwcr_dp.sv =====
// ----------------------------------------------------------------------------
// ltwcr_dp
// shared multiplier, accumulator, target update, clamp and result register
// ----------------------------------------------------------------------------
module ltwcr_dp #(
    parameter int MAX_WORKERS    = 255,
    parameter int LOAD_FRAC_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ltwcr_pkg::t_ctrl             i_ctrl,
    input  ltwcr_pkg::t_cfg              i_cfg,
    input  logic [ltwcr_pkg::LOAD_W-1:0] i_load_sample,
    input  logic                         i_prime,
    output ltwcr_pkg::t_dp_stat          o_stat,
    ltwcr_out_if.source                  o_out
);
    import ltwcr_pkg::*;

    localparam int WK_W  = ($clog2(MAX_WORKERS + 1) > CNT_W) ?
                           $clog2(MAX_WORKERS + 1) : CNT_W;
    localparam int TGT_W = WK_W + LOAD_FRAC_BITS;
    localparam int CL_W  = CNT_W + LOAD_FRAC_BITS;
    localparam int PRE_W = ((TGT_W > PRE_O_W) ? TGT_W : PRE_O_W) + 2;
    localparam logic [TGT_W-1:0] TGT_RESET = TGT_W'(MAX_WORKERS) << LOAD_FRAC_BITS;
    localparam logic [CL_W:0]    CEIL_ADD  = (CL_W + 1)'((1 << LOAD_FRAC_BITS) - 1);

    logic [LOAD_W-1:0]       r_sample;
    logic                    r_prime;
    logic [LOAD_W-1:0]       r_prev;
    logic [TGT_W-1:0]        r_target;
    logic signed [PRE_O_W-1:0] r_def;
    logic [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic [LOAD_W-1:0]       r_recent;
    logic signed [PRE_W-1:0] r_pre;

    logic                      r_out_valid;
    logic [CNT_W-1:0]          r_wc;
    logic [LOAD_W-1:0]         r_out_recent;
    logic signed [PRE_O_W-1:0] r_out_pre;
    logic [LOAD_W-1:0]         r_out_echo;
    logic                      r_out_sv;

    t_uword w_u;
    logic   w_go;
    logic   w_load_out;

    assign w_u        = i_ctrl.u;
    assign w_go       = i_ctrl.exec;
    assign w_load_out = w_go && (w_u.emit != EM_NONE);

    // multiplier operands
    logic [LOAD_W-1:0] w_ma;
    logic [KC_W-1:0]   w_mk;

    always_comb begin
        case (w_u.mul_a)
            MA_SAMPLE: w_ma = r_sample;
            MA_PREV:   w_ma = r_prev;
            MA_DEF:    w_ma = r_def[LOAD_W-1:0];
            default:   w_ma = r_sample;
        endcase
        case (w_u.mul_k)
            MK_K:     w_mk = K_Q16;
            MK_KM1:   w_mk = KM1_Q16;
            MK_RECIP: w_mk = RECIP3;
            default:  w_mk = K_Q16;
        endcase
    end

    // recent load: round half up, floor at zero, saturate high
    logic                    w_acc_pos;
    logic signed [ACC_W-1:0] w_rnd;
    logic [LOAD_W-1:0]       w_recent;

    assign w_acc_pos = !r_acc[ACC_W-1] && (r_acc != '0);
    assign w_rnd     = r_acc + ACC_W'(32768);

    always_comb begin
        if (!w_acc_pos) begin
            w_recent = '0;
        end else if (|w_rnd[ACC_W-1:16+LOAD_W]) begin
            w_recent = '1;
        end else begin
            w_recent = w_rnd[16+LOAD_W-1:16];
        end
    end

    // target step: a third of a surplus deficit, all of a negative one
    logic                    w_def_pos;
    logic signed [PRE_W-1:0] w_step;
    logic signed [PRE_W-1:0] w_pre;

    assign w_def_pos = !r_def[PRE_O_W-1] && (r_def != '0);
    assign w_step    = w_def_pos ?
                       $signed(PRE_W'(r_prod[PROD_W-1:RECIP3_SH])) : PRE_W'(r_def);
    assign w_pre     = $signed(PRE_W'(r_target)) + w_step;

    // clamp, round up and apply min/max
    logic signed [PRE_W-1:0] w_src;
    logic [CL_W-1:0]         w_hi;
    logic [CL_W-1:0]         w_clamped;
    logic [CL_W:0]           w_ceil_sum;
    logic [CNT_W-1:0]        w_ceil;
    logic [CNT_W-1:0]        w_count;

    assign w_src      = (w_u.emit == EM_REG) ? r_pre : $signed(PRE_W'(r_target));
    assign w_hi       = {i_cfg.worker_max, {LOAD_FRAC_BITS{1'b0}}};
    assign w_ceil_sum = {1'b0, w_clamped} + CEIL_ADD;
    assign w_ceil     = w_ceil_sum[LOAD_FRAC_BITS+CNT_W-1:LOAD_FRAC_BITS];

    always_comb begin
        if (w_src[PRE_W-1]) begin
            w_clamped = '0;
        end else if (w_src > $signed(PRE_W'(w_hi))) begin
            w_clamped = w_hi;
        end else begin
            w_clamped = w_src[CL_W-1:0];
        end
        if (i_cfg.load_target == '0) begin
            w_count = i_cfg.worker_max;
        end else if (i_cfg.worker_max == '0) begin
            w_count = '0;
        end else if (w_ceil < i_cfg.worker_min) begin
            w_count = i_cfg.worker_min;
        end else begin
            w_count = w_ceil;
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_sample <= i_load_sample;
            r_prime  <= i_prime;
        end
        if (w_go && w_u.mul_en) begin
            r_prod <= PROD_W'(w_ma) * PROD_W'(w_mk);
        end
        if (w_go && w_u.ld_def) begin
            r_def <= $signed({1'b0, i_cfg.load_target}) - $signed({1'b0, r_sample});
        end
        if (w_go) begin
            case (w_u.acc_op)
                ACC_LOAD: r_acc <= $signed(ACC_W'(r_prod));
                ACC_SUB:  r_acc <= r_acc - $signed(ACC_W'(r_prod));
                default:  r_acc <= r_acc;
            endcase
        end
        if (w_go && w_u.ld_stats) begin
            r_recent <= w_recent;
            r_pre    <= w_pre;
        end
        if (w_load_out) begin
            r_wc <= w_count;
            case (w_u.emit)
                EM_REG: begin
                    r_out_recent <= r_recent;
                    r_out_pre    <= r_pre[PRE_O_W-1:0];
                    r_out_echo   <= r_sample;
                    r_out_sv     <= 1'b1;
                end
                EM_PRIME: begin
                    r_out_recent <= '0;
                    r_out_pre    <= '0;
                    r_out_echo   <= r_sample;
                    r_out_sv     <= 1'b0;
                end
                default: begin
                    r_out_recent <= '0;
                    r_out_pre    <= '0;
                    r_out_echo   <= '0;
                    r_out_sv     <= 1'b0;
                end
            endcase
        end
    end

    // regulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_target    <= TGT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go && (w_u.emit == EM_REG || w_u.emit == EM_PRIME)) begin
                r_prev <= r_sample;
            end
            if (w_go && w_u.emit == EM_REG) begin
                r_target <= TGT_W'(w_clamped);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.is_prime = r_prime;
    assign o_stat.bypass   = (i_cfg.load_target == '0) || (i_cfg.worker_max == '0);
    assign o_stat.out_free = !r_out_valid || o_out.ready;

    assign o_out.valid               = r_out_valid;
    assign o_out.worker_count        = r_wc;
    assign o_out.recent_load         = r_out_recent;
    assign o_out.target_before_clamp = r_out_pre;
    assign o_out.load_echo           = r_out_echo;
    assign o_out.stats_valid         = r_out_sv;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// load_target_worker_count_regulator: directed and random tick streams with
// reconfiguration between phases, each result checked against a cycle-free
// predictor of the regulator kept inside this module
// ----------------------------------------------------------------------------
module testbench;
    import ltwcr_pkg::*;

    // register index that maps to no register, writes to it must be dropped
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // inverse exponential average gains, q16, decay exp(-5/60)
    localparam longint DECAY_GAIN_Q16  = 819655;
    localparam longint DECAY_CROSS_Q16 = 754119;

    localparam int     FRAC_BITS       = 8;
    localparam longint LOAD_FULL_SCALE = (longint'(1) << LOAD_W) - 1;
    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
    localparam longint GOAL_RESET_Q8   = longint'(255) << FRAC_BITS;

    // cycles allowed after the last result before the block counts as idle
    localparam int SETTLE_CYCLES = 8;
    // cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT   = 2000;

    typedef struct packed {
        logic [CNT_W-1:0]          worker_count;
        logic [LOAD_W-1:0]         recent_load;
        logic signed [PRE_O_W-1:0] target_before_clamp;
        logic [LOAD_W-1:0]         load_echo;
        logic                      stats_valid;
    } t_tick_result;

    logic clk = 1'b0;
    logic rst_n;

    ltwcr_in_if  tick_ch ();
    ltwcr_out_if result_ch ();
    ltwcr_cfg_if cfg_ch ();

    load_target_worker_count_regulator DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (tick_ch),
        .o_out   (result_ch),
        .i_cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // predictor state: registers and regulator state as the block holds them
    // ------------------------------------------------------------------
    logic [LOAD_W-1:0] cfg_load_target;
    logic [CNT_W-1:0]  cfg_worker_max;
    logic [CNT_W-1:0]  cfg_worker_min;
    logic [LOAD_W-1:0] prev_load_q8;
    longint            worker_goal_q8;

    t_tick_result expected_results[$];

    int  err_count;
    int  result_no;
    int  sink_hold;
    int  quiet_cycles;
    bit  src_idle_on;
    bit  snk_idle_on;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // worker goal limited to [0, worker_max] whole workers
    function automatic longint clamp_goal(input longint goal);
        longint hi;
        hi = longint'(cfg_worker_max) << FRAC_BITS;
        if (goal < 0) goal = 0;
        if (goal > hi) goal = hi;
        return goal;
    endfunction

    // round a clamped goal up to whole workers, then apply max and min
    function automatic logic [CNT_W-1:0] workers_from(input longint goal);
        longint n;
        n = (goal + (longint'(1) << FRAC_BITS) - 1) >>> FRAC_BITS;
        if (n > longint'(cfg_worker_max)) n = longint'(cfg_worker_max);
        if (n < longint'(cfg_worker_min)) n = longint'(cfg_worker_min);
        return n[CNT_W-1:0];
    endfunction

    function automatic t_tick_result predict_tick(input logic [LOAD_W-1:0] sample,
                                                  input logic prime);
        t_tick_result r;
        longint num;
        longint est;
        longint deficit;
        longint pre;
        r = '0;
        // prime only records the sample, the count comes from the held goal
        if (prime) begin
            r.load_echo  = sample;
            prev_load_q8 = sample;
            if (cfg_load_target == '0)
                r.worker_count = cfg_worker_max;
            else if (cfg_worker_max != '0)
                r.worker_count = workers_from(clamp_goal(worker_goal_q8));
            return r;
        end
        // regulation off: run the configured maximum, state untouched
        if (cfg_load_target == '0) begin
            r.worker_count = cfg_worker_max;
            return r;
        end
        // zero maximum: no workers, state untouched
        if (cfg_worker_max == '0) return r;

        // undo the exponential average to estimate the last interval's load
        num = longint'(sample) * DECAY_GAIN_Q16 - longint'(prev_load_q8) * DECAY_CROSS_Q16;
        if (num <= 0) begin
            est = 0;
        end else begin
            est = (num + 32768) >>> 16;
            if (est > LOAD_FULL_SCALE) est = LOAD_FULL_SCALE;
        end
        prev_load_q8 = sample;

        // a third of a shortfall, all of a surplus
        deficit = longint'(cfg_load_target) - longint'(sample);
        if (deficit > 0) worker_goal_q8 += deficit / 3;
        else worker_goal_q8 += deficit;
        pre = worker_goal_q8;
        worker_goal_q8 = clamp_goal(pre);

        r.worker_count        = workers_from(worker_goal_q8);
        r.recent_load         = est[LOAD_W-1:0];
        r.target_before_clamp = pre[PRE_O_W-1:0];
        r.load_echo           = sample;
        r.stats_valid         = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // error reporting
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // tick source: random gap per transaction, inputs move on the falling edge
    // ------------------------------------------------------------------
    task automatic send_tick(input logic [LOAD_W-1:0] sample, input logic prime);
        int gap;
        t_tick_result want;
        gap = src_idle_on ? int'($urandom_range(0, 9)) : 0;
        @(negedge clk);
        // valid only drops when a gap is drawn, so back-to-back stays high
        if (gap > 0) begin
            tick_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.valid       = 1'b1;
        tick_ch.load_sample = sample;
        tick_ch.prime       = prime;
        do begin
            @(posedge clk);
        end while (!tick_ch.ready);
        want = predict_tick(sample, prime);
        expected_results.insert(expected_results.size(), want);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_idle();
        @(negedge clk);
        tick_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [1:0] index, input logic [LOAD_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = index;
        cfg_ch.data  = data;
        do begin
            @(posedge clk);
        end while (!cfg_ch.ready);
        case (index)
            CFG_LOAD_TARGET: cfg_load_target = data;
            CFG_WORKER_MAX:  cfg_worker_max  = data[CNT_W-1:0];
            CFG_WORKER_MIN:  cfg_worker_min  = data[CNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result sink: ready held low for a random stall after each transaction
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            result_ch.ready = 1'b0;
        end else begin
            result_ch.ready = 1'b1;
        end
    end

    // result checker, every accepted result against the oldest prediction
    always @(posedge clk) begin : check_results
        t_tick_result want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            result_no++;
            sink_hold = snk_idle_on ? int'($urandom_range(0, 9)) : 0;
            if (expected_results.size() == 0) begin
                report_error($sformatf("result %0d arrived with no tick outstanding",
                                       result_no));
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (result_ch.worker_count !== want.worker_count)
                    report_error($sformatf("result %0d worker_count: got %0d, expected %0d",
                                           result_no, result_ch.worker_count,
                                           want.worker_count));
                if (result_ch.recent_load !== want.recent_load)
                    report_error($sformatf("result %0d recent_load: got %0d, expected %0d",
                                           result_no, result_ch.recent_load,
                                           want.recent_load));
                if (result_ch.target_before_clamp !== want.target_before_clamp)
                    report_error($sformatf(
                        "result %0d target_before_clamp: got %0d, expected %0d",
                        result_no, result_ch.target_before_clamp,
                        want.target_before_clamp));
                if (result_ch.load_echo !== want.load_echo)
                    report_error($sformatf("result %0d load_echo: got %0d, expected %0d",
                                           result_no, result_ch.load_echo, want.load_echo));
                if (result_ch.stats_valid !== want.stats_valid)
                    report_error($sformatf("result %0d stats_valid: got %0b, expected %0b",
                                           result_no, result_ch.stats_valid,
                                           want.stats_valid));
            end
        end
    end

    // watchdog: too long without any transaction on any channel means a hang
    always @(posedge clk) begin
        if (rst_n) begin
            if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("ERROR @%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                    $display("** load_target_worker_count_regulator: FAILED **");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset registers leave regulation off: every tick runs worker_max (8)
    task automatic test_disabled_after_reset();
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        send_tick(LOAD_MAX, 1'b1);
        send_tick('0, 1'b0);
        send_tick(LOAD_MAX, 1'b0);
    endtask

    // full-scale samples and deficits around one lsb
    task automatic test_regulation_extremes();
        wait_idle();
        write_reg(CFG_WORKER_MAX, 18'd255);
        write_reg(CFG_WORKER_MIN, 18'd0);
        write_reg(CFG_LOAD_TARGET, 18'd1024);
        // prime with zero so the next estimate saturates
        send_tick('0, 1'b1);
        // full-scale sample: estimate saturates, surplus drives the goal below zero
        send_tick(LOAD_MAX, 1'b0);
        // big drop: estimate goes negative and is held at zero
        send_tick('0, 1'b0);
        send_tick(18'd1024, 1'b0);
        // shortfall of one lsb, its third truncates to nothing
        send_tick(18'd1023, 1'b0);
        send_tick(18'd1025, 1'b0);
        wait_idle();
        // largest target: goal climbs past the maximum, pre-clamp value at its top
        write_reg(CFG_LOAD_TARGET, LOAD_MAX);
        repeat (3) send_tick('0, 1'b0);
    endtask

    // minimum over maximum, spare index, zero maximum, regulation off
    task automatic test_special_settings();
        wait_idle();
        write_reg(CFG_LOAD_TARGET, 18'd1);
        // upper data bits must not reach the 8-bit registers
        write_reg(CFG_WORKER_MAX, {10'h3FF, 8'd10});
        write_reg(CFG_WORKER_MIN, 18'd200);
        send_tick(18'd512, 1'b0);
        send_tick(18'h2AAAA, 1'b1);
        wait_idle();
        write_reg(CFG_SPARE, LOAD_MAX);
        send_tick('0, 1'b0);
        wait_idle();
        write_reg(CFG_WORKER_MAX, 18'd0);
        send_tick(18'h15555, 1'b0);
        send_tick(18'h2AAAA, 1'b1);
        wait_idle();
        // regulation off returns worker_max, here with a nonzero minimum below it
        write_reg(CFG_LOAD_TARGET, 18'd0);
        write_reg(CFG_WORKER_MAX, 18'd255);
        send_tick(LOAD_MAX, 1'b0);
    endtask

    // phases of random ticks, fresh registers per phase
    task automatic test_random_ticks();
        logic [LOAD_W-1:0] lt;
        logic [CNT_W-1:0]  wmax;
        logic [CNT_W-1:0]  wmin;
        logic [9:0]        junk;
        longint            s;
        int                pick;
        for (int phase = 0; phase < 12; phase++) begin
            wait_idle();
            // idling on both sides, one side, or none
            src_idle_on = (phase % 4) != 2 && (phase % 4) != 3;
            snk_idle_on = (phase % 4) != 1 && (phase % 4) != 3;

            case (phase % 8)
                0:       lt = LOAD_MAX;
                1:       lt = '0;
                2:       lt = 18'd1;
                default: lt = ($urandom_range(0, 3) == 0) ?
                              LOAD_W'($urandom_range(1, LOAD_MAX)) :
                              LOAD_W'($urandom_range(256, 16 * 256));
            endcase
            case (phase % 5)
                0:       wmax = 8'd255;
                1:       wmax = 8'd0;
                2:       wmax = 8'd1;
                default: wmax = CNT_W'($urandom_range(0, 255));
            endcase
            case (phase % 6)
                0:       wmin = 8'd255;
                1:       wmin = 8'd0;
                2:       wmin = CNT_W'($urandom_range(0, 255));
                default: wmin = CNT_W'($urandom_range(0, wmax));
            endcase
            junk = 10'($urandom_range(0, 1023));
            write_reg(CFG_LOAD_TARGET, lt);
            write_reg(CFG_WORKER_MAX, {junk, wmax});
            junk = 10'($urandom_range(0, 1023));
            write_reg(CFG_WORKER_MIN, {junk, wmin});

            // well-formed stream: prime first, then samples mostly near the target, with occasional primes
            send_tick(lt, 1'b1);
            for (int n = 0; n < 140; n++) begin
                // hold off once in a while until everything has come back
                if (n == 70 && phase % 3 == 1) wait_idle();
                pick = int'($urandom_range(0, 99));
                if (pick < 75) begin
                    s = longint'(lt) + longint'($urandom_range(0, 1536)) - 768;
                    if (s < 0) s = 0;
                    if (s > LOAD_FULL_SCALE) s = LOAD_FULL_SCALE;
                end else if (pick < 92) begin
                    s = longint'($urandom_range(0, LOAD_MAX));
                end else if (pick < 96) begin
                    s = ($urandom_range(0, 1) == 0) ? 0 : LOAD_FULL_SCALE;
                end else begin
                    s = longint'($urandom_range(0, LOAD_MAX));
                end
                send_tick(s[LOAD_W-1:0], pick >= 96);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        // every block input known from time zero
        tick_ch.valid       = 1'b0;
        tick_ch.load_sample = '0;
        tick_ch.prime       = 1'b0;
        result_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_LOAD_TARGET;
        cfg_ch.data         = '0;
        rst_n               = 1'b0;

        // predictor reset values match the block's
        cfg_load_target = '0;
        cfg_worker_max  = 8'd8;
        cfg_worker_min  = '0;
        prev_load_q8    = '0;
        worker_goal_q8  = GOAL_RESET_Q8;

        err_count    = 0;
        result_no    = 0;
        sink_hold    = 0;
        quiet_cycles = 0;
        src_idle_on  = 1'b0;
        snk_idle_on  = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_disabled_after_reset();
        test_regulation_extremes();
        test_special_settings();
        test_random_ticks();

        // drain and let the block settle before the verdict
        wait_idle();
        if (err_count == 0) begin
            $display("** load_target_worker_count_regulator: PASSED **");
        end else begin
            $display("** load_target_worker_count_regulator: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ltwcr_pkg.sv
rtl/core/ltwcr_if.sv
rtl/core/ltwcr_seq.sv
rtl/core/ltwcr_dp.sv
rtl/core/load_target_worker_count_regulator.sv
test/testbench.sv
